// ----- design/loc_pkg.sv -----
// Package for the lock-order cycle checker.
// Field widths, status codes and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package loc_pkg;

    localparam int LOCK_ID_W = 5;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 5;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_REL_EMPTY   = 3'd1,
        ST_REL_NOT_TOP = 3'd2,
        ST_DEADLOCK    = 3'd3,
        ST_STACK_FULL  = 3'd4
    } t_status;

    typedef struct packed {
        logic    latch_in;
        logic    set_status;
        t_status status;
        logic    set_dead;
        logic    push;
        logic    pop;
        logic    top_load;
        logic    chk_cap;
        logic    srch_pick;
        logic    srch_merge;
        logic    commit;
        logic    out_load;
    } t_loc_cmd;

    typedef struct packed {
        logic mode;
        logic depth_zero;
        logic depth_one;
        logic depth_full;
        logic top_eq;
        logic edge_known;
        logic pend_empty;
        logic hit;
        logic out_free;
    } t_loc_sts;

endpackage

`default_nettype wire

// ----- design/loc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module loc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- design/loc_ctrl.sv -----
// Controller FSM for the lock-order cycle checker.
// Depends on loc_pkg; drives the datapath by command struct, reads its status struct.
`default_nettype none

module loc_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire loc_pkg::t_loc_sts i_sts,
    output loc_pkg::t_loc_cmd  o_cmd
);
    import loc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EVAL  = 7'b0000010,
        S_EDGE  = 7'b0000100,
        S_PICK  = 7'b0001000,
        S_MERGE = 7'b0010000,
        S_POPW  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.mode) begin
                    if (i_sts.depth_zero) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_REL_EMPTY;
                        n_state = S_OUT;
                    end else if (!i_sts.top_eq) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_REL_NOT_TOP;
                        n_state = S_OUT;
                    end else if (i_sts.depth_one) begin
                        o_cmd.pop = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        o_cmd.pop = 1'b1;
                        n_state = S_POPW;
                    end
                end else begin
                    if (i_sts.depth_full) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_STACK_FULL;
                        n_state = S_OUT;
                    end else if (i_sts.depth_zero || i_sts.top_eq) begin
                        o_cmd.push = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_EDGE;
                    end
                end
            end
            S_EDGE: begin
                o_cmd.chk_cap = 1'b1;
                if (i_sts.edge_known) begin
                    o_cmd.push = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (i_sts.pend_empty) begin
                    o_cmd.commit = 1'b1;
                    o_cmd.push   = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.srch_pick = 1'b1;
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                if (i_sts.hit) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_DEADLOCK;
                    o_cmd.set_dead   = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.srch_merge = 1'b1;
                    n_state = S_PICK;
                end
            end
            S_POPW: begin
                o_cmd.top_load = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/loc_dp.sv -----
// Datapath of the lock-order cycle checker: held stack, order graph, search masks.
// Depends on loc_pkg and loc_ram; steered by loc_ctrl.
`default_nettype none

module loc_dp #(
    parameter int NUM_LOCKS  = 32,
    parameter int HOLD_DEPTH = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_mode,
    input  wire [loc_pkg::LOCK_ID_W-1:0]       i_lock_id,
    input  wire                                i_out_ready,
    input  wire loc_pkg::t_loc_cmd             i_cmd,
    output loc_pkg::t_loc_sts                  o_sts,
    output logic                               o_out_valid,
    output logic [loc_pkg::STATUS_W-1:0]       o_status,
    output logic [loc_pkg::LOCK_ID_W-1:0]      o_cycle_from,
    output logic [loc_pkg::LOCK_ID_W-1:0]      o_cycle_to,
    output logic [loc_pkg::COUNT_W-1:0]        o_held_count
);
    import loc_pkg::*;

    localparam int LW  = $clog2(NUM_LOCKS);
    localparam int SAW = $clog2(HOLD_DEPTH);
    localparam int DW  = $clog2(HOLD_DEPTH + 1);
    localparam int NID = 2 ** LOCK_ID_W;

    // lock number folding into range
    logic [LW-1:0] w_mod_tbl [NID];
    for (genvar v = 0; v < NID; v++) begin : g_mod
        assign w_mod_tbl[v] = LW'(v % NUM_LOCKS);
    end

    logic [DW-1:0]        r_depth;
    logic [NUM_LOCKS-1:0] r_row_vld;
    logic                 r_rd_vld;
    logic                 r_out_vld;
    logic                 r_mode;
    logic [LW-1:0]        r_lock;
    logic [LW-1:0]        r_top;
    logic [NUM_LOCKS-1:0] r_top_row;
    logic [NUM_LOCKS-1:0] r_vis;
    logic [NUM_LOCKS-1:0] r_pend;
    t_status              r_status;
    logic [LW-1:0]        r_from;
    logic [LW-1:0]        r_to;

    logic [NUM_LOCKS-1:0] w_ram_row;
    logic [NUM_LOCKS-1:0] w_row;
    logic [NUM_LOCKS-1:0] w_lock_bit;
    logic [NUM_LOCKS-1:0] w_sel_bit;
    logic [LW-1:0]        w_sel;
    logic [LW-1:0]        w_graddr;
    logic [DW-1:0]        w_pop_idx;
    logic [LW-1:0]        w_stk_rdata;

    assign w_lock_bit = NUM_LOCKS'(1) << r_lock;
    assign w_sel_bit  = NUM_LOCKS'(1) << w_sel;
    assign w_row      = w_ram_row & {NUM_LOCKS{r_rd_vld}};
    assign w_graddr   = i_cmd.srch_pick ? w_sel : r_top;
    assign w_pop_idx  = r_depth - DW'(2);

    always_comb begin
        w_sel = '0;
        for (int i = NUM_LOCKS - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                w_sel = LW'(i);
            end
        end
    end

    loc_ram #(
        .WIDTH (NUM_LOCKS),
        .DEPTH (NUM_LOCKS)
    ) u_graph (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (r_top),
        .i_wdata (r_top_row | w_lock_bit),
        .i_raddr (w_graddr),
        .o_rdata (w_ram_row)
    );

    loc_ram #(
        .WIDTH (LW),
        .DEPTH (HOLD_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_depth[SAW-1:0]),
        .i_wdata (r_lock),
        .i_raddr (w_pop_idx[SAW-1:0]),
        .o_rdata (w_stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= '0;
            r_row_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_depth <= r_depth + DW'(1);
            end else if (i_cmd.pop) begin
                r_depth <= r_depth - DW'(1);
            end
            if (i_cmd.commit) begin
                r_row_vld[r_top] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_row_vld[w_graddr];
        if (i_cmd.latch_in) begin
            r_mode   <= i_mode;
            r_lock   <= w_mod_tbl[i_lock_id];
            r_status <= ST_OK;
            r_from   <= '0;
            r_to     <= '0;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.set_dead) begin
            r_from <= r_top;
            r_to   <= r_lock;
        end
        if (i_cmd.push) begin
            r_top <= r_lock;
        end else if (i_cmd.top_load) begin
            r_top <= w_stk_rdata;
        end
        if (i_cmd.chk_cap) begin
            r_top_row <= w_row;
            r_vis     <= w_lock_bit;
            r_pend    <= w_lock_bit;
        end else if (i_cmd.srch_pick) begin
            r_pend <= r_pend & ~w_sel_bit;
        end else if (i_cmd.srch_merge) begin
            r_pend <= r_pend | (w_row & ~r_vis);
            r_vis  <= r_vis | w_row;
        end
        if (i_cmd.out_load) begin
            o_status     <= r_status;
            o_cycle_from <= LOCK_ID_W'(r_from);
            o_cycle_to   <= LOCK_ID_W'(r_to);
            o_held_count <= COUNT_W'(r_depth);
        end
    end

    assign o_out_valid = r_out_vld;

    always_comb begin
        o_sts.mode       = r_mode;
        o_sts.depth_zero = (r_depth == '0);
        o_sts.depth_one  = (r_depth == DW'(1));
        o_sts.depth_full = (r_depth == DW'(HOLD_DEPTH));
        o_sts.top_eq     = (r_top == r_lock);
        o_sts.edge_known = w_row[r_lock];
        o_sts.pend_empty = (r_pend == '0);
        o_sts.hit        = w_row[r_top];
        o_sts.out_free   = !r_out_vld || i_out_ready;
    end

endmodule

`default_nettype wire

// ----- design/lock_order_cycle_checker.sv -----
// Lock-order cycle checker, top level: controller and datapath; needs loc_pkg, loc_ctrl, loc_dp.
// One word in flight; the next is accepted the cycle after its result is loaded.
// From accept to result register: evaluate, then output when no edge is looked up; evaluate,
// edge check, output for a known edge; evaluate, pop wait, output for a release that leaves locks
// held; a new edge adds a pick and a merge step per lock searched; a stalled result register adds its wait.
// Synchronous active-low reset: empty held stack, empty order graph, no result.
`default_nettype none

module lock_order_cycle_checker #(
    parameter int NUM_LOCKS  = 32,
    parameter int HOLD_DEPTH = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire                               i_mode,
    input  wire [loc_pkg::LOCK_ID_W-1:0]      i_lock_id,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [loc_pkg::STATUS_W-1:0]      o_status,
    output logic [loc_pkg::LOCK_ID_W-1:0]     o_cycle_from,
    output logic [loc_pkg::LOCK_ID_W-1:0]     o_cycle_to,
    output logic [loc_pkg::COUNT_W-1:0]       o_held_count
);
    import loc_pkg::*;

    t_loc_cmd w_cmd;
    t_loc_sts w_sts;

    loc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    loc_dp #(
        .NUM_LOCKS  (NUM_LOCKS),
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (i_mode),
        .i_lock_id    (i_lock_id),
        .i_out_ready  (i_out_ready),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .o_cycle_from (o_cycle_from),
        .o_cycle_to   (o_cycle_to),
        .o_held_count (o_held_count)
    );

endmodule

`default_nettype wire
